// ===== design/arfl_pkg.sv =====
// package for the angle reflectivity unit
// widths, sequencer states and shared constants; no dependencies
package arfl_pkg;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS = 20;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIN2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAN2 = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_DIVP, ST_DIVR, ST_DIVS, ST_DIVK,
    ST_ACC, ST_M1, ST_M2, ST_M3, ST_ROUND, ST_OUT
  } arfl_state_t;
endpackage

// ===== design/angle_reflectivity_from_logs_unit.sv =====
// aki-richards reflectivity, one shared restoring divider and a shared 32x32 product step
// depends on arfl_pkg
// the divider produces one quotient bit a cycle; elastic mode runs four divisions, acoustic two,
// and a zero mean skips them and returns the error flag
// one beat at a time, in_tready low while busy and until the result is taken; a start-of-log beat gives no result
// reset: synchronous active low, mode elastic, angle zero, no previous sample
module angle_reflectivity_from_logs_unit
  import arfl_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // p_velocity, s_velocity, density
  input  logic        in_tuser,   // first_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // reflectivity, divide_error, saturated, zero fill
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int SW = SAMPLE_BITS + 1;          // sum width
  localparam int DW = SW + FRAC_BITS + 1;       // dividend width
  localparam int CW = $clog2(DW + 1);
  localparam int VB = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
  localparam logic [63:0] CAP = 64'd1 << 60;
  localparam logic [CW-1:0] PP_LAST = CW'(4);

  arfl_state_t state_r, state_nxt;
  logic mode_r;
  logic [16:0] sin2_r;
  logic [23:0] tan2_r;
  logic [SAMPLE_BITS-1:0] lp_r, ls_r, lr_r, cp_r, cs_r, cr_r;
  logic have_r;
  logic [SW-1:0] sp_r, ss_r, sr_r;
  logic [DW-1:0] num_r, quo_r;
  logic [SW:0]   rem_r;
  logic [SW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic signed [23:0] qp_r, qs_r, qr_r;
  logic [63:0] kq_r, y_r;
  logic [127:0] pacc_r;
  logic signed [63:0] acc_r;
  logic ovf_r;
  logic [20:0] res_r;
  logic err_r, sat_r, ovalid_r;

  logic [SAMPLE_BITS-1:0] vp, vs, vr;
  assign vp = SAMPLE_BITS'(in_tdata[VB-1:0]);
  assign vs = SAMPLE_BITS'(in_tdata[16+VB-1:16]);
  assign vr = SAMPLE_BITS'(in_tdata[32+VB-1:32]);

  assign in_tready = (state_r == ST_IDLE) && !ovalid_r;
  wire take = in_tvalid && in_tready;
  wire div_done = (cnt_r == CW'(DW));

  // divider step
  logic [SW:0] rem_sh;
  logic [SW:0] rem_sub;
  always_comb begin
    rem_sh = {rem_r[SW-1:0], num_r[DW-1]};
    rem_sub = rem_sh - {1'b0, den_r};
  end

  // 32x32 product step shared by the two k steps, four partial products each
  logic [31:0] pa_c, pb_c;
  logic [63:0] pp_c;
  logic [127:0] pterm_c;
  logic [63:0] mres;
  always_comb begin
    pa_c = cnt_r[0] ? y_r[63:32] : y_r[31:0];
    pb_c = cnt_r[1] ? kq_r[63:32] : kq_r[31:0];
    pp_c = pa_c * pb_c;
    case (cnt_r[1:0])
      2'd0:    pterm_c = 128'(pp_c);
      2'd3:    pterm_c = 128'(pp_c) << 64;
      default: pterm_c = 128'(pp_c) << 32;
    endcase
    mres = (pacc_r[127:64] != '0) ? CAP : 64'(pacc_r[63:FRAC_BITS]);
  end

  // accumulator terms
  logic [24:0] a_c;
  logic signed [49:0] accp_c;
  logic signed [23:0] n_c;
  logic [23:0] nmag_c;
  logic [40:0] y0_c;
  always_comb begin
    a_c = 25'h10000 + 25'(tan2_r);
    accp_c = $signed({1'b0, a_c}) * qp_r;
    n_c = (qs_r <<< 1) + qr_r;
    nmag_c = n_c[23] ? 24'(-n_c) : 24'(n_c);
    y0_c = 41'(sin2_r) * 41'(nmag_c);
  end

  function automatic logic [DW-1:0] mag_num(input logic [SAMPLE_BITS-1:0] c,
                                           input logic [SAMPLE_BITS-1:0] o);
    logic [SAMPLE_BITS-1:0] m;
    m = (c >= o) ? c - o : o - c;
    return DW'({m, 1'b0}) << FRAC_BITS;
  endfunction

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (take && !in_tuser && have_r) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = (sp_r == '0 || sr_r == '0 || (mode_r && ss_r == '0)) ?
                            ST_OUT : ST_DIVP;
      ST_DIVP:  if (div_done) state_nxt = ST_DIVR;
      ST_DIVR:  if (div_done) state_nxt = mode_r ? ST_DIVS : ST_ACC;
      ST_DIVS:  if (div_done) state_nxt = ST_DIVK;
      ST_DIVK:  if (div_done) state_nxt = ST_ACC;
      ST_ACC:   state_nxt = mode_r ? ST_M1 : ST_ROUND;
      ST_M1:    if (cnt_r == PP_LAST) state_nxt = ST_M2;
      ST_M2:    if (cnt_r == PP_LAST) state_nxt = ST_M3;
      ST_M3:    state_nxt = ST_ROUND;
      ST_ROUND: state_nxt = ST_OUT;
      ST_OUT:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r <= 1'b1;
      sin2_r <= '0;
      tan2_r <= '0;
      have_r <= 1'b0;
      lp_r <= '0; ls_r <= '0; lr_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MODE: mode_r <= cfg_data[0];
          REG_SIN2: sin2_r <= cfg_data[16:0];
          REG_TAN2: tan2_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) ovalid_r <= 1'b0;
      if (take) begin
        have_r <= 1'b1;
        if (in_tuser || !have_r) begin
          lp_r <= vp; ls_r <= vs; lr_r <= vr;
        end
      end
      if (state_r == ST_OUT) begin
        ovalid_r <= 1'b1;
        lp_r <= cp_r; ls_r <= cs_r; lr_r <= cr_r;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: if (take) begin
        cp_r <= vp; cs_r <= vs; cr_r <= vr;
        sp_r <= SW'(vp) + SW'(lp_r);
        ss_r <= SW'(vs) + SW'(ls_r);
        sr_r <= SW'(vr) + SW'(lr_r);
      end
      ST_CHECK: begin
        err_r <= 1'b1; sat_r <= 1'b0; res_r <= '0;
        num_r <= mag_num(cp_r, lp_r); den_r <= sp_r;
        rem_r <= '0; cnt_r <= '0;
      end
      ST_DIVP, ST_DIVR, ST_DIVS, ST_DIVK: begin
        if (!div_done) begin
          num_r <= num_r << 1;
          if (!rem_sub[SW]) begin
            rem_r <= rem_sub; quo_r <= {quo_r[DW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh; quo_r <= {quo_r[DW-2:0], 1'b0};
          end
          cnt_r <= cnt_r + 1'b1;
        end else begin
          rem_r <= '0; cnt_r <= '0;
          unique case (state_r)
            ST_DIVP: begin
              qp_r <= (cp_r >= lp_r) ? 24'(quo_r) : -24'(quo_r);
              num_r <= mag_num(cr_r, lr_r); den_r <= sr_r;
            end
            ST_DIVR: begin
              qr_r <= (cr_r >= lr_r) ? 24'(quo_r) : -24'(quo_r);
              num_r <= mag_num(cs_r, ls_r); den_r <= ss_r;
            end
            ST_DIVS: begin
              qs_r <= (cs_r >= ls_r) ? 24'(quo_r) : -24'(quo_r);
              num_r <= DW'(ss_r) << FRAC_BITS; den_r <= sp_r;
            end
            default: kq_r <= 64'(quo_r);
          endcase
        end
      end
      ST_ACC: begin
        acc_r <= 64'(accp_c) + (64'(qr_r) <<< 16);
        y_r <= 64'(y0_c);
        ovf_r <= !n_c[23] && (n_c != '0);
        pacc_r <= '0;
      end
      ST_M1, ST_M2: begin
        if (cnt_r != PP_LAST) begin
          pacc_r <= pacc_r + pterm_c;
          cnt_r <= cnt_r + 1'b1;
        end else begin
          y_r <= mres;
          pacc_r <= '0;
          cnt_r <= '0;
        end
      end
      ST_M3: acc_r <= ovf_r ? acc_r - $signed(y_r << 2) : acc_r + $signed(y_r << 2);
      ST_ROUND: begin
        logic [63:0] m, r;
        m = acc_r[63] ? -acc_r : acc_r;
        r = (m + 64'd1048576) >> 21;
        err_r <= 1'b0;
        if (acc_r[63]) begin
          if (r > 64'd1048576) begin res_r <= 21'h100000; sat_r <= 1'b1; end
          else begin res_r <= -r[20:0]; sat_r <= 1'b0; end
        end else begin
          if (r > 64'd1048575) begin res_r <= 21'h0FFFFF; sat_r <= 1'b1; end
          else begin res_r <= r[20:0]; sat_r <= 1'b0; end
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata = {1'b0, sat_r, err_r, res_r};
endmodule

// ===== design/arfl_checker.sv =====
// port-level checks for the reflectivity unit
// no package dependencies, bound to the top level
module arfl_checker (
  input logic clk, rst_n, in_tvalid, in_tready, out_tvalid, out_tready,
  input logic [23:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("hold");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("busy");
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[21] |-> out_tdata[20:0] == '0 && !out_tdata[22]) else $error("err");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[23]) else $error("fill");
endmodule

bind angle_reflectivity_from_logs_unit arfl_checker u_chk (.*);
